>>> rtl/mtrs_pkg.sv
// Shared types and constants for the monotonic tick-rate scaler.
package mtrs_pkg;

	localparam int DATA_W = 64;   // raw count and tick value
	localparam int FREQ_W = 50;   // widest frequency register
	localparam int PRI_W  = 44;   // primary frequency register
	localparam int IDX_W  = 2;    // configuration register index
	localparam int CNT_W  = 7;    // shared unit step counter
	localparam int GK_W   = 6;    // common power-of-two count in the gcd

	localparam int DIV_STEPS = DATA_W;
	localparam int MUL_STEPS = FREQ_W;

	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	localparam logic [IDX_W-1:0] REG_PRIMARY_FREQ   = 2'd0;
	localparam logic [IDX_W-1:0] REG_ALTERNATE_FREQ = 2'd1;
	localparam logic [IDX_W-1:0] REG_USE_ALTERNATE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_TARGET_FREQ    = 2'd3;

	typedef enum logic {
		OP_DIV,
		OP_MUL
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ovf;
	} unit_sts_t;

endpackage

>>> rtl/mtrs_unit.sv
// Shared iterative unit: restoring divide and MSB-first shift-add multiply, one bit per cycle.
module mtrs_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mtrs_pkg::unit_cmd_t             cmd,
	input  logic [mtrs_pkg::DATA_W-1:0]     opa,
	input  logic [mtrs_pkg::FREQ_W-1:0]     opb,
	output mtrs_pkg::unit_sts_t             sts,
	output logic [mtrs_pkg::DATA_W-1:0]     quo,
	output logic [mtrs_pkg::FREQ_W-1:0]     rem
);

	logic                           busy_q;
	logic                           done_q;
	logic                           ovf_q;
	mtrs_pkg::unit_op_t             op_q;
	logic [mtrs_pkg::CNT_W-1:0]     cnt_q;
	logic [mtrs_pkg::DATA_W-1:0]    acc_q;    // dividend/quotient or product
	logic [mtrs_pkg::DATA_W-1:0]    mcand_q;
	logic [mtrs_pkg::FREQ_W-1:0]    opb_q;    // divisor or multiplier (shifts out MSB first)
	logic [mtrs_pkg::FREQ_W-1:0]    rem_q;

	// divide step
	logic [mtrs_pkg::FREQ_W:0]      shifted;
	logic [mtrs_pkg::FREQ_W:0]      diff;
	logic                           ge;
	logic [mtrs_pkg::FREQ_W-1:0]    rem_nx;
	// multiply step
	logic [mtrs_pkg::DATA_W-1:0]    addend;
	logic [mtrs_pkg::DATA_W:0]      msum;

	always_comb begin
		shifted = {rem_q, acc_q[mtrs_pkg::DATA_W-1]};
		diff    = shifted - {1'b0, opb_q};
		ge      = shifted >= {1'b0, opb_q};
		rem_nx  = ge ? diff[mtrs_pkg::FREQ_W-1:0] : shifted[mtrs_pkg::FREQ_W-1:0];
		addend  = opb_q[mtrs_pkg::FREQ_W-1] ? mcand_q : '0;
		msum    = {1'b0, acc_q[mtrs_pkg::DATA_W-2:0], 1'b0} + {1'b0, addend};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
			op_q    <= mtrs_pkg::OP_DIV;
			cnt_q   <= '0;
			acc_q   <= '0;
			mcand_q <= '0;
			opb_q   <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q  <= 1'b1;
				op_q    <= cmd.op;
				ovf_q   <= 1'b0;
				mcand_q <= opa;
				opb_q   <= opb;
				rem_q   <= '0;
				if (cmd.op == mtrs_pkg::OP_DIV) begin
					acc_q <= opa;
					cnt_q <= mtrs_pkg::CNT_W'(mtrs_pkg::DIV_STEPS - 1);
				end else begin
					acc_q <= '0;
					cnt_q <= mtrs_pkg::CNT_W'(mtrs_pkg::MUL_STEPS - 1);
				end
			end else if (busy_q) begin
				if (op_q == mtrs_pkg::OP_DIV) begin
					acc_q <= {acc_q[mtrs_pkg::DATA_W-2:0], ge};
					rem_q <= rem_nx;
				end else begin
					acc_q <= msum[mtrs_pkg::DATA_W-1:0];
					ovf_q <= ovf_q | acc_q[mtrs_pkg::DATA_W-1] | msum[mtrs_pkg::DATA_W];
					opb_q <= {opb_q[mtrs_pkg::FREQ_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign quo      = acc_q;
	assign rem      = rem_q;

endmodule

>>> rtl/monotonic_tick_rate_scaler_core.sv
// Top level: rational tick-rate conversion with saturation and a monotonic output.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------
//   input    | in_valid / in_stall     | raw_count[63:0]
//   output   | out_valid / out_stall   | tick_value[63:0]
//   config   | cfg_we (no wait)        | cfg_index[1:0], cfg_data[49:0]
//
// One transaction at a time. A normal sample costs the binary gcd (one
// subtract or shift per cycle), four 64-step divides and two 50-step
// multiplies on the shared unit. A zero source or target frequency skips
// the arithmetic. in_stall is high from acceptance until the result is
// loaded into the output register; a stalled result there does not block
// the next input, only the load of the next result. arst_n clears the
// registers to their reset frequencies and the highest tick value to zero.
module monotonic_tick_rate_scaler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mtrs_pkg::DATA_W-1:0]     raw_count,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mtrs_pkg::DATA_W-1:0]     tick_value,
	input  logic                            cfg_we,
	input  logic [mtrs_pkg::IDX_W-1:0]      cfg_index,
	input  logic [mtrs_pkg::FREQ_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV_FROM,
		ST_DIV_TO,
		ST_DIV_RAW,
		ST_MUL_FRAC,
		ST_DIV_FRAC,
		ST_MUL_WHOLE,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t                          state_q;

	// configuration registers
	logic [mtrs_pkg::PRI_W-1:0]      primary_freq_q;
	logic [mtrs_pkg::FREQ_W-1:0]     alternate_freq_q;
	logic                            use_alternate_q;
	logic [mtrs_pkg::FREQ_W-1:0]     target_freq_q;

	// working registers
	logic [mtrs_pkg::DATA_W-1:0]     raw_q;     // raw sample, later the fraction
	logic [mtrs_pkg::FREQ_W-1:0]     from_q;
	logic [mtrs_pkg::FREQ_W-1:0]     to_q;
	logic [mtrs_pkg::FREQ_W-1:0]     ga_q;
	logic [mtrs_pkg::FREQ_W-1:0]     gb_q;
	logic [mtrs_pkg::GK_W-1:0]       gk_q;
	logic [mtrs_pkg::DATA_W-1:0]     whole_q;
	logic                            ovf_q;
	logic [mtrs_pkg::DATA_W-1:0]     scaled_q;
	logic [mtrs_pkg::DATA_W-1:0]     highest_q;
	logic [mtrs_pkg::DATA_W-1:0]     tick_q;
	logic                            out_valid_q;

	// shared unit command
	logic                            start_q;
	mtrs_pkg::unit_op_t              op_q;
	logic [mtrs_pkg::DATA_W-1:0]     opa_q;
	logic [mtrs_pkg::FREQ_W-1:0]     opb_q;

	mtrs_pkg::unit_cmd_t             ucmd;
	mtrs_pkg::unit_sts_t             usts;
	logic [mtrs_pkg::DATA_W-1:0]     uquo;
	logic [mtrs_pkg::FREQ_W-1:0]     urem;

	logic [mtrs_pkg::FREQ_W-1:0]     sel_from;
	logic [mtrs_pkg::FREQ_W-1:0]     gcd_val;
	logic [mtrs_pkg::DATA_W:0]       sum;
	logic                            out_load;
	logic                            unit_go;   // next unit operation is loaded this cycle, start_q issues it

	assign ucmd.start = start_q;
	assign ucmd.op    = op_q;

	mtrs_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ucmd),
		.opa    (opa_q),
		.opb    (opb_q),
		.sts    (usts),
		.quo    (uquo),
		.rem    (urem)
	);

	always_comb begin
		sel_from = use_alternate_q ? alternate_freq_q
		                           : {{(mtrs_pkg::FREQ_W-mtrs_pkg::PRI_W){1'b0}}, primary_freq_q};
		gcd_val  = ga_q << gk_q;
		sum      = {1'b0, whole_q} + {1'b0, raw_q};
		out_load = !out_valid_q || !out_stall;
		case (state_q)
			ST_GCD:      unit_go = ga_q[0] && gb_q[0] && (ga_q == gb_q);
			ST_DIV_FROM,
			ST_DIV_TO,
			ST_DIV_RAW,
			ST_MUL_FRAC,
			ST_DIV_FRAC: unit_go = usts.done;
			default:     unit_go = 1'b0;
		endcase
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign tick_value = tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			primary_freq_q   <= mtrs_pkg::PRI_W'(1000000000);
			alternate_freq_q <= mtrs_pkg::FREQ_W'(1);
			use_alternate_q  <= 1'b0;
			target_freq_q    <= mtrs_pkg::FREQ_W'(1000000000);
			raw_q            <= '0;
			from_q           <= '0;
			to_q             <= '0;
			ga_q             <= '0;
			gb_q             <= '0;
			gk_q             <= '0;
			whole_q          <= '0;
			ovf_q            <= 1'b0;
			scaled_q         <= '0;
			highest_q        <= '0;
			tick_q           <= '0;
			out_valid_q      <= 1'b0;
			start_q          <= 1'b0;
			op_q             <= mtrs_pkg::OP_DIV;
			opa_q            <= '0;
			opb_q            <= '0;
		end else begin
			start_q <= unit_go;

			if (cfg_we) begin
				case (cfg_index)
					mtrs_pkg::REG_PRIMARY_FREQ:   primary_freq_q   <= cfg_data[mtrs_pkg::PRI_W-1:0];
					mtrs_pkg::REG_ALTERNATE_FREQ: alternate_freq_q <= cfg_data;
					mtrs_pkg::REG_USE_ALTERNATE:  use_alternate_q  <= cfg_data[0];
					mtrs_pkg::REG_TARGET_FREQ:    target_freq_q    <= cfg_data;
					default: ;
				endcase
			end

			// a new result loads the output register, otherwise an accepted one leaves it
			if (state_q == ST_OUT && out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						raw_q  <= raw_count;
						from_q <= sel_from;
						to_q   <= target_freq_q;
						ga_q   <= sel_from;
						gb_q   <= target_freq_q;
						gk_q   <= '0;
						if (sel_from == '0) begin
							scaled_q <= mtrs_pkg::ALL_ONES;
							state_q  <= ST_OUT;
						end else if (target_freq_q == '0) begin
							scaled_q <= '0;
							state_q  <= ST_OUT;
						end else begin
							state_q <= ST_GCD;
						end
					end
				end
				// binary gcd, one shift or subtract per cycle
				ST_GCD: begin
					if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						gk_q <= gk_q + 1'b1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_q == gb_q) begin
						ga_q    <= gcd_val;
						op_q    <= mtrs_pkg::OP_DIV;
						opa_q   <= {{(mtrs_pkg::DATA_W-mtrs_pkg::FREQ_W){1'b0}}, from_q};
						opb_q   <= gcd_val;
						state_q <= ST_DIV_FROM;
					end else if (ga_q > gb_q) begin
						ga_q <= ga_q - gb_q;
					end else begin
						gb_q <= gb_q - ga_q;
					end
				end
				ST_DIV_FROM: begin
					if (usts.done) begin
						from_q  <= uquo[mtrs_pkg::FREQ_W-1:0];
						op_q    <= mtrs_pkg::OP_DIV;
						opa_q   <= {{(mtrs_pkg::DATA_W-mtrs_pkg::FREQ_W){1'b0}}, to_q};
						opb_q   <= ga_q;
						state_q <= ST_DIV_TO;
					end
				end
				ST_DIV_TO: begin
					if (usts.done) begin
						to_q    <= uquo[mtrs_pkg::FREQ_W-1:0];
						op_q    <= mtrs_pkg::OP_DIV;
						opa_q   <= raw_q;
						opb_q   <= from_q;
						state_q <= ST_DIV_RAW;
					end
				end
				ST_DIV_RAW: begin
					if (usts.done) begin
						whole_q <= uquo;
						op_q    <= mtrs_pkg::OP_MUL;
						opa_q   <= {{(mtrs_pkg::DATA_W-mtrs_pkg::FREQ_W){1'b0}}, urem};
						opb_q   <= to_q;
						state_q <= ST_MUL_FRAC;
					end
				end
				// remainder times target, wrapped at 64 bits
				ST_MUL_FRAC: begin
					if (usts.done) begin
						op_q    <= mtrs_pkg::OP_DIV;
						opa_q   <= uquo;
						opb_q   <= from_q;
						state_q <= ST_DIV_FRAC;
					end
				end
				ST_DIV_FRAC: begin
					if (usts.done) begin
						raw_q   <= uquo;
						op_q    <= mtrs_pkg::OP_MUL;
						opa_q   <= whole_q;
						opb_q   <= to_q;
						state_q <= ST_MUL_WHOLE;
					end
				end
				// unit flags any product bit past 64
				ST_MUL_WHOLE: begin
					if (usts.done) begin
						whole_q <= uquo;
						ovf_q   <= usts.ovf;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					scaled_q <= (ovf_q || sum[mtrs_pkg::DATA_W]) ? mtrs_pkg::ALL_ONES
					                                             : sum[mtrs_pkg::DATA_W-1:0];
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						if (scaled_q > highest_q) begin
							highest_q <= scaled_q;
							tick_q    <= scaled_q;
						end else begin
							tick_q    <= highest_q;
						end
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a waiting result never exceeds the running maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> tick_q <= highest_q)
		else $error("tick_value above running maximum");

	// the running maximum never falls
	assert property (@(posedge clk) disable iff (!arst_n)
		highest_q >= $past(highest_q))
		else $error("running maximum decreased");

	// the sequencer only starts the unit while it is free
	assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !usts.busy)
		else $error("shared unit started while busy");

	// unit completion only lands in a state that waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		usts.done |-> (state_q == ST_DIV_FROM || state_q == ST_DIV_TO ||
		               state_q == ST_DIV_RAW || state_q == ST_MUL_FRAC ||
		               state_q == ST_DIV_FRAC || state_q == ST_MUL_WHOLE))
		else $error("unit done outside a waiting state");

endmodule

>>> tb/sv/monotonic_tick_rate_scaler_core_test.sv
// Self-checking testbench for monotonic_tick_rate_scaler_core: random rates, climbing samples.
module monotonic_tick_rate_scaler_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TIMEOUT_CYCLES = 12_000_000;
	localparam int unsigned SETTLE_CYCLES  = 8;    // idle cycles before a rate change
	localparam int unsigned DRAIN_TAIL     = 700;  // about one worst-case conversion
	localparam int unsigned RANDOM_PHASES  = 10;
	localparam int unsigned PHASE_ITEMS    = 115;

	localparam logic [mtrs_pkg::FREQ_W-1:0] TGT_MAX = '1;

	// Crystal and bus rates seen in practice; all fit the 44-bit primary register.
	localparam logic [mtrs_pkg::DATA_W-1:0] COMMON_RATES [8] = '{
		64'd1_000_000_000, 64'd24_000_000, 64'd19_200_000, 64'd32_768,
		64'd10_000_000, 64'd3_579_545, 64'd14_318_180, 64'd100_000_000
	};

	// Mirror of the register file plus the running peak. Every accepted sample
	// pushes the tick value the block must return for it.
	class tick_ledger;
		logic [mtrs_pkg::PRI_W-1:0]  pri_hz;
		logic [mtrs_pkg::FREQ_W-1:0] alt_hz;
		logic                        alt_sel;
		logic [mtrs_pkg::FREQ_W-1:0] tgt_hz;
		logic [mtrs_pkg::DATA_W-1:0] peak_ticks;
		logic [mtrs_pkg::DATA_W-1:0] pending_ticks[$];
		int unsigned                 mismatches;

		function new();
			pri_hz     = mtrs_pkg::PRI_W'(1_000_000_000);
			alt_hz     = mtrs_pkg::FREQ_W'(1);
			alt_sel    = 1'b0;
			tgt_hz     = mtrs_pkg::FREQ_W'(1_000_000_000);
			peak_ticks = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [mtrs_pkg::IDX_W-1:0] idx,
				logic [mtrs_pkg::FREQ_W-1:0] data);
			case (idx)
				mtrs_pkg::REG_PRIMARY_FREQ:   pri_hz  = data[mtrs_pkg::PRI_W-1:0];  // upper bits dropped
				mtrs_pkg::REG_ALTERNATE_FREQ: alt_hz  = data;
				mtrs_pkg::REG_USE_ALTERNATE:  alt_sel = data[0];
				mtrs_pkg::REG_TARGET_FREQ:    tgt_hz  = data;
				default: ;
			endcase
		endfunction

		function logic [mtrs_pkg::DATA_W-1:0] source_hz();
			return alt_sel ? mtrs_pkg::DATA_W'(alt_hz) : mtrs_pkg::DATA_W'(pri_hz);
		endfunction

		// Rational conversion raw * dst / src after gcd reduction, saturating.
		function logic [mtrs_pkg::DATA_W-1:0] scale_count(logic [mtrs_pkg::DATA_W-1:0] raw,
				logic [mtrs_pkg::DATA_W-1:0] src, logic [mtrs_pkg::DATA_W-1:0] dst);
			logic [mtrs_pkg::DATA_W-1:0] a, b, rem, whole, frac;
			if (src == 0) return mtrs_pkg::ALL_ONES;
			if (dst == 0) return '0;
			a = src;
			b = dst;
			while (b != 0) begin
				rem = a % b;
				a   = b;
				b   = rem;
			end
			src   = src / a;
			dst   = dst / a;
			whole = raw / src;
			frac  = ((raw % src) * dst) / src;  // remainder product wraps at 64 bits
			if (whole > mtrs_pkg::ALL_ONES / dst) return mtrs_pkg::ALL_ONES;
			whole = whole * dst;
			if (frac > mtrs_pkg::ALL_ONES - whole) return mtrs_pkg::ALL_ONES;
			return whole + frac;
		endfunction

		function void take_raw_count(logic [mtrs_pkg::DATA_W-1:0] raw);
			logic [mtrs_pkg::DATA_W-1:0] scaled;
			scaled = scale_count(raw, source_hz(), mtrs_pkg::DATA_W'(tgt_hz));
			if (scaled > peak_ticks) peak_ticks = scaled;
			pending_ticks.push_back(peak_ticks);
		endfunction

		function void compare_tick(logic [mtrs_pkg::DATA_W-1:0] seen);
			logic [mtrs_pkg::DATA_W-1:0] want;
			if (pending_ticks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: tick_value %h with no transaction outstanding", $time, seen);
				return;
			end
			want = pending_ticks.pop_front();
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: tick_value expected %h got %h", $time, want, seen);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [mtrs_pkg::DATA_W-1:0]   raw_count = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [mtrs_pkg::DATA_W-1:0]   tick_value;
	logic                          cfg_we    = 1'b0;
	logic [mtrs_pkg::IDX_W-1:0]    cfg_index = '0;
	logic [mtrs_pkg::FREQ_W-1:0]   cfg_data  = '0;

	bit         steady = 1'b0;  // both sides run without idle cycles while set
	tick_ledger ledger;

	monotonic_tick_rate_scaler_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_count  (raw_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tick_value (tick_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Output side: mostly short random stalls, now and then a long one so a
	// finished result sits in the output register while the next one is
	// being computed behind it.
	initial begin : receiver_pace
		forever begin
			if (!steady && $urandom_range(0, 9999) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 700)) @(posedge clk);
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < 34);
				@(posedge clk);
			end
		end
	end

	// Result transactions; sampled at the edge, so stall and valid are the
	// values the block saw.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) ledger.compare_tick(tick_value);
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// One sample transaction. Called at a clock edge, normally the one that
	// accepted the previous sample; valid is either dropped for a gap or
	// simply kept high with the new payload.
	task automatic send_raw(input logic [mtrs_pkg::DATA_W-1:0] raw);
		int unsigned gap;
		gap = 0;
		if (!steady) begin
			while ($urandom_range(0, 99) < 34) gap++;
			if ($urandom_range(0, 39) == 0) gap += $urandom_range(1, 700);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		raw_count <= raw;
		do @(posedge clk); while (in_stall);
		ledger.take_raw_count(raw);
	endtask

	// Drop valid and wait until every result is back, so the block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.pending_ticks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mtrs_pkg::IDX_W-1:0] idx,
			input logic [mtrs_pkg::FREQ_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		ledger.set_reg(idx, data);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [mtrs_pkg::FREQ_W-1:0] pick_rate(input int unsigned width);
		logic [mtrs_pkg::FREQ_W-1:0] rate;
		logic [mtrs_pkg::FREQ_W-1:0] widest;
		widest = mtrs_pkg::FREQ_W'((64'd1 << width) - 64'd1);
		case ($urandom_range(0, 5))
			0:       rate = mtrs_pkg::FREQ_W'(COMMON_RATES[$urandom_range(0, 7)]);
			1:       rate = $urandom_range(0, 1) ? widest : mtrs_pkg::FREQ_W'(1);
			default: rate = mtrs_pkg::FREQ_W'({$urandom, $urandom}
			                                  >> (64 - $urandom_range(1, width)));
		endcase
		return (rate == 0) ? mtrs_pkg::FREQ_W'(1) : rate;
	endfunction

	// The peak never comes back down, so most samples are aimed a little above
	// it (back-computed through the current ratio); the rest are drawn from zero
	// up to that aim, so they can land at or under the peak and exercise the hold path.
	function automatic logic [mtrs_pkg::DATA_W-1:0] next_raw();
		logic [mtrs_pkg::DATA_W-1:0] step, climb, src;
		logic [127:0]                goal;
		src   = ledger.source_hz();
		step  = {$urandom, $urandom} >> $urandom_range(24, 63);
		goal  = (({64'd0, ledger.peak_ticks} + step) * src) / ledger.tgt_hz
			+ $urandom_range(0, 2);
		climb = (goal[127:64] != 0) ? mtrs_pkg::ALL_ONES : goal[63:0];
		if (climb == mtrs_pkg::ALL_ONES || $urandom_range(0, 99) < 70) return climb;
		return {$urandom, $urandom} % (climb + 64'd1);
	endfunction

	task automatic random_phase(input int unsigned count);
		logic [mtrs_pkg::FREQ_W-1:0] pri, alt, tgt;
		logic                        sel;
		logic [mtrs_pkg::DATA_W-1:0] src;
		pri = pick_rate(mtrs_pkg::PRI_W);
		if ($urandom_range(0, 3) == 0)
			pri[mtrs_pkg::FREQ_W-1:mtrs_pkg::PRI_W] =
				(mtrs_pkg::FREQ_W-mtrs_pkg::PRI_W)'($urandom);
		alt = pick_rate(mtrs_pkg::FREQ_W);
		sel = 1'($urandom_range(0, 1));
		tgt = pick_rate(mtrs_pkg::FREQ_W);
		src = sel ? mtrs_pkg::DATA_W'(alt) : mtrs_pkg::DATA_W'(pri[mtrs_pkg::PRI_W-1:0]);
		// near the top, stop the ratio from multiplying the peak any further
		if (ledger.peak_ticks[mtrs_pkg::DATA_W-1:59] != 0) tgt = src[mtrs_pkg::FREQ_W-1:0];
		// keep climbing samples under 2^62 so they do not clip to all ones
		while (({64'd0, ledger.peak_ticks} + (128'd1 << 41)) * src
				>= ({78'd0, tgt} << 62)) begin
			if (tgt < (TGT_MAX >> 1)) tgt = (tgt << 1) | 1'b1;
			else if (sel) alt = (alt >> 1) | 1'b1;
			else pri[mtrs_pkg::PRI_W-1:0] = (pri[mtrs_pkg::PRI_W-1:0] >> 1) | 1'b1;
			src = sel ? mtrs_pkg::DATA_W'(alt) : mtrs_pkg::DATA_W'(pri[mtrs_pkg::PRI_W-1:0]);
		end
		settle();
		write_reg(mtrs_pkg::REG_PRIMARY_FREQ, pri);
		write_reg(mtrs_pkg::REG_ALTERNATE_FREQ, alt);
		write_reg(mtrs_pkg::REG_USE_ALTERNATE, mtrs_pkg::FREQ_W'(sel));
		write_reg(mtrs_pkg::REG_TARGET_FREQ, tgt);
		repeat (count) send_raw(next_raw());
	endtask

	initial begin : stimulus
		logic [mtrs_pkg::DATA_W-1:0] fit_whole;
		ledger = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset rates, 1 GHz to 1 GHz: ticks follow the samples; the last one
		// is smaller and must come back as the held peak.
		send_raw(64'd0);
		send_raw(64'd1);
		send_raw(64'd12345);
		send_raw(64'd100);

		// Primary written with every data bit set (only 44 stick), 1 Hz target:
		// huge raw samples shrink to about 2^20 ticks.
		settle();
		write_reg(mtrs_pkg::REG_PRIMARY_FREQ, '1);
		write_reg(mtrs_pkg::REG_TARGET_FREQ, mtrs_pkg::FREQ_W'(1));
		send_raw('1);
		send_raw(64'h8000_0000_0000_0000);
		send_raw(64'hAAAA_AAAA_AAAA_AAAA);
		send_raw(64'h5555_5555_5555_5555);

		// Alternate at full width over a full-width target: reduces to 1:1.
		settle();
		write_reg(mtrs_pkg::REG_ALTERNATE_FREQ, '1);
		write_reg(mtrs_pkg::REG_USE_ALTERNATE, mtrs_pkg::FREQ_W'(1));
		write_reg(mtrs_pkg::REG_TARGET_FREQ, '1);
		send_raw(64'd2_000_000);

		// Zero target: scaled value is zero, output holds the peak.
		settle();
		write_reg(mtrs_pkg::REG_TARGET_FREQ, '0);
		send_raw('1);
		send_raw(64'd5);

		// 44-bit source against 50-bit target share a factor of 3; the
		// remainder times target runs well past 64 bits and wraps.
		settle();
		write_reg(mtrs_pkg::REG_USE_ALTERNATE, mtrs_pkg::FREQ_W'(0));
		write_reg(mtrs_pkg::REG_TARGET_FREQ, '1);
		send_raw(64'h0000_03FF_FFFF_FFF0);
		send_raw(64'h0000_0EAA_AAAA_AA9A);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			steady = (p == 4);
			random_phase(PHASE_ITEMS);
		end
		steady = 1'b0;

		// Saturation goes last: once the peak is all ones every later result
		// is all ones too. Source 2 over target 2^50-1 (coprime); fit_whole is
		// the largest whole part whose product still fits in 64 bits.
		settle();
		write_reg(mtrs_pkg::REG_PRIMARY_FREQ, mtrs_pkg::FREQ_W'(2));
		write_reg(mtrs_pkg::REG_USE_ALTERNATE, mtrs_pkg::FREQ_W'(0));
		write_reg(mtrs_pkg::REG_TARGET_FREQ, '1);
		fit_whole = mtrs_pkg::ALL_ONES / mtrs_pkg::DATA_W'(TGT_MAX);
		send_raw(fit_whole << 1);            // just under 2^64, no fraction
		send_raw((fit_whole << 1) | 64'd1);  // fraction tips the sum over
		send_raw((fit_whole + 64'd1) << 1);  // whole times target overflows
		send_raw('1);

		// zero source frequency, then zero source with a zero target
		settle();
		write_reg(mtrs_pkg::REG_PRIMARY_FREQ, '0);
		send_raw(64'd77);
		settle();
		write_reg(mtrs_pkg::REG_ALTERNATE_FREQ, '0);
		write_reg(mtrs_pkg::REG_USE_ALTERNATE, mtrs_pkg::FREQ_W'(1));
		write_reg(mtrs_pkg::REG_TARGET_FREQ, '0);
		send_raw(64'd0);

		settle();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending_ticks.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/mtrs_pkg.sv
rtl/mtrs_unit.sv
rtl/monotonic_tick_rate_scaler_core.sv
tb/sv/monotonic_tick_rate_scaler_core_test.sv
